// ----- hdl/deq_pkg.sv -----
// Shared types and constants for the double-ended queue core.
// Used by deq_ctrl, deq_cell and double_ended_queue_core; depends on nothing.
`timescale 1ns / 1ps

package deq_pkg;

    // Field widths of the request and result words.
    localparam int DATA_W   = 64;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    // Stream widths: tdata is padded to whole bytes.
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 72;

    // Default queue depth.
    localparam int DEPTH_DEFAULT = 16;

    // Request codes.
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Broadcast operation for the cell row; each bit is set only for a
    // request that is accepted and succeeds.
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
    } deq_op_t;

endpackage

// ----- hdl/double_ended_queue_core.sv -----
// Top level of the double-ended queue: stream ports, result register, cell row.
// Depends on deq_pkg, deq_ctrl and deq_cell.
//
//   Port group   Dir   tdata (low bit up)               tuser
//   s_*          in    data_in[63:0]                    mode[1:0]
//   m_*          out   data_out[63:0], fill_level[68:64] status[1:0]
//
// The fill counter, every cell and the result register update at the edge that
// accepts a request; the result word is loaded into the output register there.
// A new request is taken each cycle while the result register is empty or being
// drained. Both ends of the queue sit at cell 0 of one of two cell rows, so no
// request reads a cell chosen by the count.
// Reset clears the counter and the result valid flag; cell contents are not reset.
`timescale 1ns / 1ps

module double_ended_queue_core #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [deq_pkg::S_TDATA_W-1:0]     s_tdata,  // data_in[63:0]
    input  logic [deq_pkg::MODE_W-1:0]        s_tuser,  // mode[1:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [deq_pkg::M_TDATA_W-1:0]     m_tdata,  // data_out[63:0], fill_level[68:64]
    output logic [deq_pkg::STATUS_W-1:0]      m_tuser   // status[1:0]
);

    localparam int CNT_W = $clog2(DEPTH+1);

    logic                          accept;
    deq_pkg::deq_op_t              op;
    logic [deq_pkg::STATUS_W-1:0]  status;
    logic [CNT_W-1:0]              count;
    logic [CNT_W-1:0]              count_after;
    logic [deq_pkg::DATA_W-1:0]    push_word;
    logic [deq_pkg::DATA_W-1:0]    a_word [DEPTH];
    logic [deq_pkg::DATA_W-1:0]    b_word [DEPTH];
    logic [deq_pkg::DATA_W-1:0]    pop_word;

    logic                          m_valid_reg;
    logic [deq_pkg::STATUS_W-1:0]  m_status_reg;
    logic [deq_pkg::DATA_W-1:0]    m_data_reg;
    logic [deq_pkg::FILL_W-1:0]    m_fill_reg;

    // A word is taken whenever the result register is free or draining.
    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign push_word = s_tdata[deq_pkg::DATA_W-1:0];

    deq_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .mode       (s_tuser),
        .op         (op),
        .status     (status),
        .count      (count),
        .count_after(count_after)
    );

    // Row of cells; cell 0 takes pushed words and the last cell shifts in zero.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [deq_pkg::DATA_W-1:0] a_left;
        logic [deq_pkg::DATA_W-1:0] a_right;
        logic [deq_pkg::DATA_W-1:0] b_left;
        logic [deq_pkg::DATA_W-1:0] b_right;

        if (i == 0) begin : g_head
            assign a_left = push_word;
            assign b_left = push_word;
        end else begin : g_body
            assign a_left = a_word[i-1];
            assign b_left = b_word[i-1];
        end

        if (i == DEPTH-1) begin : g_last
            assign a_right = '0;
            assign b_right = '0;
        end else begin : g_inner
            assign a_right = a_word[i+1];
            assign b_right = b_word[i+1];
        end

        deq_cell #(
            .DEPTH(DEPTH),
            .INDEX(i)
        ) u_cell (
            .aclk     (aclk),
            .op       (op),
            .count    (count),
            .push_word(push_word),
            .a_left   (a_left),
            .a_right  (a_right),
            .b_left   (b_left),
            .b_right  (b_right),
            .a_word   (a_word[i]),
            .b_word   (b_word[i])
        );
    end

    // Popped word comes from the head cell of the matching row.
    always_comb begin
        pop_word = '0;
        if (op.pop_front) begin
            pop_word = a_word[0];
        end else if (op.pop_back) begin
            pop_word = b_word[0];
        end
    end

    // Result register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_status_reg <= status;
            m_data_reg   <= pop_word;
            m_fill_reg   <= deq_pkg::FILL_W'(count_after);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{(deq_pkg::M_TDATA_W - deq_pkg::DATA_W - deq_pkg::FILL_W){1'b0}},
                       m_fill_reg, m_data_reg};

endmodule

// ----- hdl/deq_cell.sv -----
// One storage cell of the queue row: a front-ordered word and a back-ordered word.
// Depends on deq_pkg for the word width and the broadcast operation type.
`timescale 1ns / 1ps

module deq_cell #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT,
    parameter int INDEX = 0
) (
    input  logic                              aclk,
    input  deq_pkg::deq_op_t                  op,
    input  logic [$clog2(DEPTH+1)-1:0]        count,
    input  logic [deq_pkg::DATA_W-1:0]        push_word,
    input  logic [deq_pkg::DATA_W-1:0]        a_left,
    input  logic [deq_pkg::DATA_W-1:0]        a_right,
    input  logic [deq_pkg::DATA_W-1:0]        b_left,
    input  logic [deq_pkg::DATA_W-1:0]        b_right,
    output logic [deq_pkg::DATA_W-1:0]        a_word,
    output logic [deq_pkg::DATA_W-1:0]        b_word
);

    localparam int CNT_W = $clog2(DEPTH+1);

    logic [deq_pkg::DATA_W-1:0] a_reg;
    logic [deq_pkg::DATA_W-1:0] a_next;
    logic [deq_pkg::DATA_W-1:0] b_reg;
    logic [deq_pkg::DATA_W-1:0] b_next;
    logic                       at_tail;

    // Set when this cell is the first free slot of both rows.
    assign at_tail = (count == CNT_W'(INDEX));

    // Row A keeps the front at cell 0; row B keeps the back at cell 0.
    // A push on the own end shifts the row outward, a pop shifts it inward,
    // and a push on the far end lands in the first free slot.
    always_comb begin
        a_next = a_reg;
        b_next = b_reg;
        if (op.push_front) begin
            a_next = a_left;
            if (at_tail) begin
                b_next = push_word;
            end
        end
        if (op.push_back) begin
            b_next = b_left;
            if (at_tail) begin
                a_next = push_word;
            end
        end
        if (op.pop_front) begin
            a_next = a_right;
        end
        if (op.pop_back) begin
            b_next = b_right;
        end
    end

    // Payload storage needs no reset.
    always_ff @(posedge aclk) begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign a_word = a_reg;
    assign b_word = b_reg;

endmodule

// ----- hdl/deq_ctrl.sv -----
// Request decoder and fill counter of the double-ended queue.
// Depends on deq_pkg for request and status codes and the operation type.
`timescale 1ns / 1ps

module deq_ctrl #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              accept,
    input  logic [deq_pkg::MODE_W-1:0]        mode,
    output deq_pkg::deq_op_t                  op,
    output logic [deq_pkg::STATUS_W-1:0]      status,
    output logic [$clog2(DEPTH+1)-1:0]        count,
    output logic [$clog2(DEPTH+1)-1:0]        count_after
);

    localparam int CNT_W = $clog2(DEPTH+1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             is_full;
    logic             is_empty;

    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    // Decode the request into a row operation and a status.
    always_comb begin
        op         = '0;
        status     = deq_pkg::STATUS_OK;
        count_next = count_reg;
        unique case (mode)
            deq_pkg::MODE_PUSH_FRONT: begin
                if (is_full) begin
                    status = deq_pkg::STATUS_FULL;
                end else begin
                    op.push_front = accept;
                    count_next    = count_reg + 1'b1;
                end
            end
            deq_pkg::MODE_PUSH_BACK: begin
                if (is_full) begin
                    status = deq_pkg::STATUS_FULL;
                end else begin
                    op.push_back = accept;
                    count_next   = count_reg + 1'b1;
                end
            end
            deq_pkg::MODE_POP_FRONT: begin
                if (is_empty) begin
                    status = deq_pkg::STATUS_EMPTY;
                end else begin
                    op.pop_front = accept;
                    count_next   = count_reg - 1'b1;
                end
            end
            deq_pkg::MODE_POP_BACK: begin
                if (is_empty) begin
                    status = deq_pkg::STATUS_EMPTY;
                end else begin
                    op.pop_back = accept;
                    count_next  = count_reg - 1'b1;
                end
            end
        endcase
    end

    // Fill counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (accept) begin
            count_reg <= count_next;
        end
    end

    assign count       = count_reg;
    assign count_after = count_next;

endmodule
